// ===== sv/vfc_pkg.sv =====
// Package for the voxel face culler: item types, operation codes, step codes and register indexes.
package vfc_pkg;

	// Operation codes carried by an input item.
	localparam logic [1:0] OP_RESTART = 2'd0;
	localparam logic [1:0] OP_WRITE   = 2'd1;
	localparam logic [1:0] OP_QUERY   = 2'd2;

	// Configuration register indexes.
	localparam logic [1:0] CFG_EXTENT_X = 2'd0;
	localparam logic [1:0] CFG_EXTENT_Y = 2'd1;
	localparam logic [1:0] CFG_EXTENT_Z = 2'd2;

	// Extent values after reset.
	localparam logic [4:0] EXTENT_X_RESET = 5'd16;
	localparam logic [6:0] EXTENT_Y_RESET = 7'd64;
	localparam logic [4:0] EXTENT_Z_RESET = 5'd16;

	// Scan steps: the centre voxel, then one neighbour per face in emit order.
	localparam logic [2:0] STEP_CENTER = 3'd0;
	localparam logic [2:0] STEP_TOP    = 3'd1;
	localparam logic [2:0] STEP_BOTTOM = 3'd2;
	localparam logic [2:0] STEP_XP     = 3'd3;
	localparam logic [2:0] STEP_XN     = 3'd4;
	localparam logic [2:0] STEP_ZP     = 3'd5;
	localparam logic [2:0] STEP_ZN     = 3'd6;

	localparam int FACES = 6;

	// Sequencer states.
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_EMIT
	} ctrl_state_t;

	// One input item.
	typedef struct packed {
		logic [1:0] operation;
		logic [3:0] voxel_x;
		logic [5:0] voxel_y;
		logic [3:0] voxel_z;
		logic [3:0] block_kind;
	} in_item_t;

	// One result item.
	typedef struct packed {
		logic [2:0]  face_dir;
		logic [3:0]  face_x;
		logic [5:0]  face_y;
		logic [3:0]  face_z;
		logic [3:0]  face_block;
		logic [18:0] first_vertex;
		logic        last_face;
	} out_item_t;

	// Request to the address unit: a voxel and the step taken from it.
	typedef struct packed {
		logic [3:0] x;
		logic [5:0] y;
		logic [3:0] z;
		logic [2:0] step;
	} addr_req_t;

endpackage

// ===== sv/vfc_addr.sv =====
// Shared address unit: neighbour coordinates, chunk boundary test and linear store address.
module vfc_addr #(
	parameter int MAX_Y = 64,
	parameter int MAX_Z = 16,
	parameter int AW    = 14
) (
	input  vfc_pkg::addr_req_t req,
	input  logic [4:0]         ex,
	input  logic [6:0]         ey,
	input  logic [4:0]         ez,
	output logic [AW-1:0]      addr,
	output logic               at_bound
);

	logic [3:0] nx;
	logic [5:0] ny;
	logic [3:0] nz;

	// Step to the neighbour unless the voxel sits on the boundary on that side.
	always_comb begin
		nx = req.x;
		ny = req.y;
		nz = req.z;
		at_bound = 1'b0;
		case (req.step)
			vfc_pkg::STEP_TOP: begin
				at_bound = (({1'b0, req.y} + 7'd1) == ey);
				if (!at_bound) ny = req.y + 6'd1;
			end
			vfc_pkg::STEP_BOTTOM: begin
				at_bound = (req.y == 6'd0);
				if (!at_bound) ny = req.y - 6'd1;
			end
			vfc_pkg::STEP_XP: begin
				at_bound = (({1'b0, req.x} + 5'd1) == ex);
				if (!at_bound) nx = req.x + 4'd1;
			end
			vfc_pkg::STEP_XN: begin
				at_bound = (req.x == 4'd0);
				if (!at_bound) nx = req.x - 4'd1;
			end
			vfc_pkg::STEP_ZP: begin
				at_bound = (({1'b0, req.z} + 5'd1) == ez);
				if (!at_bound) nz = req.z + 4'd1;
			end
			vfc_pkg::STEP_ZN: begin
				at_bound = (req.z == 4'd0);
				if (!at_bound) nz = req.z - 4'd1;
			end
			default: begin
				at_bound = 1'b0;
			end
		endcase
	end

	// Linear index: x major, then y, then z; the multipliers are constants.
	assign addr = AW'((32'(nx) * 32'(MAX_Y) + 32'(ny)) * 32'(MAX_Z) + 32'(nz));

endmodule

// ===== sv/vfc_store.sv =====
// Voxel store: single-port memory with registered read and a clearing pass after reset.
module vfc_store #(
	parameter int DEPTH = 16384,
	parameter int AW    = 14
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          we,
	input  logic [AW-1:0] addr,
	input  logic [3:0]    wdata,
	output logic [3:0]    rdata,
	output logic          busy
);

	logic [3:0]    mem [DEPTH];
	logic [AW-1:0] clr_q;
	logic          busy_q;
	logic [3:0]    rdata_q;

	// Clearing pass: one entry per cycle from address zero upwards.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q  <= '0;
			busy_q <= 1'b1;
		end else if (busy_q) begin
			if (clr_q == AW'(DEPTH - 1)) begin
				busy_q <= 1'b0;
			end else begin
				clr_q <= clr_q + AW'(1);
			end
		end
	end

	// Memory array: the clearing pass owns the write port until it finishes.
	always_ff @(posedge clk) begin
		if (busy_q) begin
			mem[clr_q] <= 4'd0;
		end else if (we) begin
			mem[addr] <= wdata;
		end
		rdata_q <= mem[addr];
	end

	assign rdata = rdata_q;
	assign busy  = busy_q;

endmodule

// ===== sv/vfc_ctrl.sv =====
// Sequencer: takes items, scans the centre voxel and six neighbours, then emits exposed faces.
module vfc_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  vfc_pkg::in_item_t   in_item,
	output logic                out_valid,
	input  logic                out_stall,
	output vfc_pkg::out_item_t  out_item,
	input  logic [4:0]          ex,
	input  logic [6:0]          ey,
	input  logic [4:0]          ez,
	input  logic                busy,
	output vfc_pkg::addr_req_t  areq,
	input  logic                at_bound,
	output logic                mem_we,
	output logic [3:0]          mem_wdata,
	input  logic [3:0]          mem_rdata
);

	vfc_pkg::ctrl_state_t state_q, state_d;
	logic [3:0]           cx_q;
	logic [5:0]           cy_q;
	logic [3:0]           cz_q;
	logic [2:0]           step_q, step_d;
	logic                 vld_s1, vld_d;
	logic [2:0]           step_s1;
	logic                 bnd_s1;
	logic [3:0]           block_q, block_d;
	logic [5:0]           mask_q, mask_d;
	logic [16:0]          count_q, count_d;
	logic                 out_valid_q, out_valid_d;
	vfc_pkg::out_item_t   out_q, out_d;
	logic                 accept;
	logic                 in_range;
	logic                 issue;
	logic [2:0]           pick_dir;
	logic [5:0]           pick;
	logic [5:0]           rest;

	assign in_stall = busy || (state_q != vfc_pkg::ST_IDLE);
	assign accept   = in_valid && !in_stall;
	assign in_range = ({1'b0, in_item.voxel_x} < ex) && ({1'b0, in_item.voxel_y} < ey)
		&& ({1'b0, in_item.voxel_z} < ez);
	assign issue    = (state_q == vfc_pkg::ST_SCAN) && (step_q <= vfc_pkg::STEP_ZN);

	// Address request: the incoming voxel while idle, the latched voxel while scanning.
	always_comb begin
		if (state_q == vfc_pkg::ST_IDLE) begin
			areq = '{x: in_item.voxel_x, y: in_item.voxel_y, z: in_item.voxel_z,
				step: vfc_pkg::STEP_CENTER};
		end else begin
			areq = '{x: cx_q, y: cy_q, z: cz_q, step: step_q};
		end
	end

	assign mem_we    = accept && (in_item.operation == vfc_pkg::OP_WRITE) && in_range;
	assign mem_wdata = in_item.block_kind;

	// Lowest pending face, which is the next one in emit order.
	always_comb begin
		pick_dir = 3'd0;
		for (int d = vfc_pkg::FACES - 1; d >= 0; d--) begin
			if (mask_q[d]) pick_dir = 3'(d);
		end
		pick = 6'd1 << pick_dir;
		rest = mask_q & ~pick;
	end

	// Next state and datapath updates.
	always_comb begin
		state_d     = state_q;
		step_d      = step_q;
		vld_d       = 1'b0;
		block_d     = block_q;
		mask_d      = mask_q;
		count_d     = count_q;
		out_valid_d = out_valid_q && out_stall;
		out_d       = out_q;
		case (state_q)
			vfc_pkg::ST_IDLE: begin
				if (accept) begin
					case (in_item.operation)
						vfc_pkg::OP_RESTART: begin
							count_d = '0;
						end
						vfc_pkg::OP_QUERY: begin
							if (in_range) begin
								state_d = vfc_pkg::ST_SCAN;
								step_d  = vfc_pkg::STEP_CENTER;
								mask_d  = '0;
							end
						end
						default: begin
							count_d = count_q;
						end
					endcase
				end
			end
			vfc_pkg::ST_SCAN: begin
				// Issue one store read per cycle; the data returns in the next cycle.
				if (issue) step_d = step_q + 3'd1;
				vld_d = issue;
				if (vld_s1) begin
					if (step_s1 == vfc_pkg::STEP_CENTER) begin
						if (mem_rdata == 4'd0) begin
							state_d = vfc_pkg::ST_IDLE;
							vld_d   = 1'b0;
						end else begin
							block_d = mem_rdata;
						end
					end else begin
						for (int d = 0; d < vfc_pkg::FACES; d++) begin
							if (step_s1 == 3'(d + 1)) mask_d[d] = bnd_s1 || (mem_rdata == 4'd0);
						end
						if (step_s1 == vfc_pkg::STEP_ZN) state_d = vfc_pkg::ST_EMIT;
					end
				end
			end
			vfc_pkg::ST_EMIT: begin
				if (mask_q == 6'd0) begin
					state_d = vfc_pkg::ST_IDLE;
				end else if (!out_valid_q || !out_stall) begin
					out_d.face_dir     = pick_dir;
					out_d.face_x       = cx_q;
					out_d.face_y       = cy_q;
					out_d.face_z       = cz_q;
					out_d.face_block   = block_q;
					out_d.first_vertex = {count_q, 2'b00};
					out_d.last_face    = (rest == 6'd0);
					out_valid_d        = 1'b1;
					count_d            = count_q + 17'd1;
					mask_d             = rest;
					if (rest == 6'd0) state_d = vfc_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = vfc_pkg::ST_IDLE;
			end
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= vfc_pkg::ST_IDLE;
			step_q      <= vfc_pkg::STEP_CENTER;
			vld_s1      <= 1'b0;
			mask_q      <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			step_q      <= step_d;
			vld_s1      <= vld_d;
			mask_q      <= mask_d;
			count_q     <= count_d;
			out_valid_q <= out_valid_d;
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			cx_q <= in_item.voxel_x;
			cy_q <= in_item.voxel_y;
			cz_q <= in_item.voxel_z;
		end
		step_s1 <= step_q;
		bnd_s1  <= at_bound;
		block_q <= block_d;
		out_q   <= out_d;
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

endmodule

// ===== sv/voxel_face_culler.sv =====
// Top level of the voxel face culler: configuration registers and the store, address unit and sequencer.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+-------------------------------------
//  in      | to block  | in_valid/in_stall  | in_item: operation, voxel, block kind
//  out     | from block| out_valid/out_stall| out_item: one exposed face
//  cfg     | to block  | cfg_we             | cfg_index, cfg_data (extents)
//
// Restart and write items, like a query outside the extents, leave the sequencer idle. A query
// reads the centre voxel and its six neighbours through the single store port, then emits one
// face per exposed side; an air centre ends the query with no faces emitted.
// After reset the store is cleared one entry per cycle, all MAX_X*MAX_Y*MAX_Z entries, while
// in_stall is high. Faces wait in an output register; a stalled output holds the sequencer
// in its emit phase, but an item is taken while the last face of a query still waits.
module voxel_face_culler #(
	parameter int MAX_X = 16,
	parameter int MAX_Y = 64,
	parameter int MAX_Z = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  vfc_pkg::in_item_t  in_item,
	output logic               out_valid,
	input  logic               out_stall,
	output vfc_pkg::out_item_t out_item,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [6:0]         cfg_data
);

	localparam int DEPTH = MAX_X * MAX_Y * MAX_Z;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [4:0]         ext_x_q;
	logic [6:0]         ext_y_q;
	logic [4:0]         ext_z_q;
	logic [4:0]         ex;
	logic [6:0]         ey;
	logic [4:0]         ez;
	vfc_pkg::addr_req_t areq;
	logic [AW-1:0]      addr;
	logic               at_bound;
	logic               mem_we;
	logic [3:0]         mem_wdata;
	logic [3:0]         mem_rdata;
	logic               busy;

	// Extent registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ext_x_q <= vfc_pkg::EXTENT_X_RESET;
			ext_y_q <= vfc_pkg::EXTENT_Y_RESET;
			ext_z_q <= vfc_pkg::EXTENT_Z_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				vfc_pkg::CFG_EXTENT_X: ext_x_q <= cfg_data[4:0];
				vfc_pkg::CFG_EXTENT_Y: ext_y_q <= cfg_data;
				vfc_pkg::CFG_EXTENT_Z: ext_z_q <= cfg_data[4:0];
				default: ext_x_q <= ext_x_q;
			endcase
		end
	end

	// Effective extents: zero acts as one, and values past the chunk size are capped.
	assign ex = (ext_x_q == 5'd0) ? 5'd1 : ((32'(ext_x_q) > MAX_X) ? 5'(MAX_X) : ext_x_q);
	assign ey = (ext_y_q == 7'd0) ? 7'd1 : ((32'(ext_y_q) > MAX_Y) ? 7'(MAX_Y) : ext_y_q);
	assign ez = (ext_z_q == 5'd0) ? 5'd1 : ((32'(ext_z_q) > MAX_Z) ? 5'(MAX_Z) : ext_z_q);

	vfc_addr #(
		.MAX_Y (MAX_Y),
		.MAX_Z (MAX_Z),
		.AW    (AW)
	) u_addr (
		.req      (areq),
		.ex       (ex),
		.ey       (ey),
		.ez       (ez),
		.addr     (addr),
		.at_bound (at_bound)
	);

	vfc_store #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_store (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (mem_we),
		.addr   (addr),
		.wdata  (mem_wdata),
		.rdata  (mem_rdata),
		.busy   (busy)
	);

	vfc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item),
		.ex        (ex),
		.ey        (ey),
		.ez        (ez),
		.busy      (busy),
		.areq      (areq),
		.at_bound  (at_bound),
		.mem_we    (mem_we),
		.mem_wdata (mem_wdata),
		.mem_rdata (mem_rdata)
	);

endmodule

// ===== sv/vfc_checker.sv =====
// Port checker for the voxel face culler, bound to the top level.
module vfc_port_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_stall,
	input vfc_pkg::in_item_t  in_item,
	input logic               out_valid,
	input logic               out_stall,
	input vfc_pkg::out_item_t out_item
);

	logic               have_prev_q;
	vfc_pkg::out_item_t prev_q;
	logic               out_take;

	assign out_take = out_valid && !out_stall;

	// Last delivered face, to compare consecutive faces of one query.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_prev_q <= 1'b0;
		end else if (out_take) begin
			have_prev_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_take) prev_q <= out_item;
	end

	// A stalled face stays in place.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_item))
		else $error("stalled face changed or vanished");

	// Faces of one query share the voxel and block kind, and their first vertex indexes step by four.
	a_face_seq: assert property (@(posedge clk) disable iff (!arst_n)
		out_take && have_prev_q && !prev_q.last_face |->
			(out_item.first_vertex == prev_q.first_vertex + 19'd4)
			&& (out_item.face_x == prev_q.face_x) && (out_item.face_y == prev_q.face_y)
			&& (out_item.face_z == prev_q.face_z)
			&& (out_item.face_block == prev_q.face_block))
		else $error("faces of one query out of sequence");

	// Faces of one query come in rising direction order.
	a_dir_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_take && have_prev_q && !prev_q.last_face |-> out_item.face_dir > prev_q.face_dir)
		else $error("face directions out of order");

	// While a face that is not the last of its query is shown, no item is taken.
	a_busy_emit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_item.last_face |-> in_stall)
		else $error("item accepted in the middle of a query");

	// A shown face never belongs to air.
	a_solid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_item.face_block != 4'd0)
		else $error("face emitted for an air voxel");

endmodule

bind voxel_face_culler vfc_port_checker u_vfc_port_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.in_item   (in_item),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_item  (out_item)
);
